/* rtl/csup_pkg.sv */
// Package for the coordinate stack: types, constants and the control store.
`timescale 1ns / 1ps

package csup_pkg;

    localparam int DEPTH      = 64;
    localparam int COORD_BITS = 8;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ENTRY_W    = 2 * COORD_BITS;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_UNIQUE = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] column_in;
        logic [7:0] row_in;
    } in_t;

    typedef struct packed {
        logic [7:0] last_column;
        logic [7:0] last_row;
        logic       list_empty;
        logic [6:0] entry_total;
        logic       was_added;
        logic       duplicate_found;
        logic       store_full;
    } out_t;

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
    localparam logic [STEP_W-1:0] STEP_PUSH     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SCAN     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_POP      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_TOPRD    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_OUT      = 3'd6;

    // jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_IN_REQ   = 3'd2;
    localparam logic [2:0] COND_MODE     = 3'd3;
    localparam logic [2:0] COND_SCAN_END = 3'd4;
    localparam logic [2:0] COND_OUT_FREE = 3'd5;

    typedef struct packed {
        logic [2:0]        cond;
        logic [STEP_W-1:0] tgt;
        logic              push;
        logic              pop;
        logic              scan;
        logic              toprd;
        logic              load_out;
    } uop_t;

    function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
        uop_t u;
        u = '0;
        case (step)
            STEP_IDLE:
            begin
                u.cond = COND_IN_REQ;
                u.tgt  = STEP_DISPATCH;
            end
            STEP_DISPATCH:
            begin
                u.cond = COND_MODE;
                u.tgt  = STEP_IDLE;
            end
            STEP_PUSH:
            begin
                u.cond = COND_ALWAYS;
                u.tgt  = STEP_TOPRD;
                u.push = 1'b1;
            end
            STEP_SCAN:
            begin
                u.cond = COND_SCAN_END;
                u.tgt  = STEP_PUSH;
                u.scan = 1'b1;
            end
            STEP_POP:
            begin
                u.cond = COND_ALWAYS;
                u.tgt  = STEP_TOPRD;
                u.pop  = 1'b1;
            end
            STEP_TOPRD:
            begin
                u.cond  = COND_ALWAYS;
                u.tgt   = STEP_OUT;
                u.toprd = 1'b1;
            end
            STEP_OUT:
            begin
                u.cond     = COND_OUT_FREE;
                u.tgt      = STEP_IDLE;
                u.load_out = 1'b1;
            end
            default:
            begin
                u.cond = COND_ALWAYS;
                u.tgt  = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

    function automatic logic [STEP_W-1:0] mode_target(input logic [1:0] mode);
        logic [STEP_W-1:0] t;
        case (mode)
            MODE_APPEND: t = STEP_PUSH;
            MODE_UNIQUE: t = STEP_SCAN;
            MODE_DELETE: t = STEP_POP;
            default:     t = STEP_TOPRD;
        endcase
        return t;
    endfunction

endpackage

/* rtl/coordinate_stack_unique_push.sv */
// Bounded stack of column/row pairs with append, unique append, delete and query.
//
// Usage: one request on the input channel (mode, column_in, row_in) yields one
// result on the output channel (newest pair, entry count, empty flag and
// added / duplicate / full flags). Both channels use valid/ready.
// A request is taken only while the control sequencer sits in its idle step;
// requests are handled one at a time.
// After the idle and dispatch steps, append pushes, delete pops and query goes
// straight to the top-of-stack read; unique append first runs a duplicate scan
// that reads one stored pair per cycle from the single read port of the pair
// memory, a duplicate ending the scan early, and then pushes. Every request
// ends with the top-of-stack read and the output step.
// The result sits in an output register; the sequencer holds in its final
// step while the receiver stalls and the previous result is still pending.
// Reset (rst_n low, asynchronous) empties the stack and drops any pending
// result; pair memory contents are not cleared and no clearing pass is run.
`timescale 1ns / 1ps

module coordinate_stack_unique_push (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  csup_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output csup_pkg::out_t out_data
);
    import csup_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               dup_reg, dup_next;
    logic               added_reg, added_next;
    logic               full_reg, full_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         mode_reg;
    logic [ENTRY_W-1:0] item_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    out_t               out_reg;

    uop_t               uop;
    logic               take;
    logic               in_req;
    logic               hit;
    logic               scan_end;
    logic               rd_en;
    logic [ADDR_W-1:0]  raddr;
    logic               wr_en;
    logic               load;
    logic               cnt_zero;
    logic               cnt_full;
    logic [COORD_BITS-1:0] in_col;
    logic [COORD_BITS-1:0] in_row;

    assign uop      = uop_rom(step_reg);
    assign in_ready = (step_reg == STEP_IDLE);
    assign in_req   = in_valid && in_ready;
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_full = (cnt_reg >= CNT_W'(DEPTH));
    assign hit      = pend_reg && (rdata_reg == item_reg);
    assign scan_end = hit || ((idx_reg == cnt_reg) && !pend_reg);
    assign in_col   = COORD_BITS'(in_data.column_in);
    assign in_row   = COORD_BITS'(in_data.row_in);

    always_comb
    begin
        case (uop.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_IN_REQ:   take = in_valid;
            COND_MODE:     take = 1'b1;
            COND_SCAN_END: take = scan_end;
            COND_OUT_FREE: take = !out_valid_reg || out_ready;
            default:       take = 1'b0;
        endcase
        if (!take)
        begin
            step_next = step_reg;
        end
        else if (uop.cond == COND_MODE)
        begin
            step_next = mode_target(mode_reg);
        end
        else
        begin
            step_next = uop.tgt;
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        dup_next   = dup_reg;
        added_next = added_reg;
        full_next  = full_reg;
        rd_en      = 1'b0;
        raddr      = idx_reg[ADDR_W-1:0];
        wr_en      = 1'b0;
        load       = uop.load_out && take;

        if (in_req)
        begin
            idx_next   = '0;
            pend_next  = 1'b0;
            dup_next   = 1'b0;
            added_next = 1'b0;
            full_next  = 1'b0;
        end

        if (uop.push && !dup_reg)
        begin
            if (cnt_full)
            begin
                full_next = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                added_next = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
            end
        end

        if (uop.pop && !cnt_zero)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        if (uop.scan)
        begin
            if (hit)
            begin
                dup_next = 1'b1;
            end
            else if (!scan_end)
            begin
                if (idx_reg != cnt_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
        end

        if (uop.toprd)
        begin
            rd_en = 1'b1;
            raddr = ADDR_W'(cnt_reg - 1'b1);
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            added_reg     <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            dup_reg       <= dup_next;
            added_reg     <= added_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            mode_reg <= in_data.mode;
            item_reg <= {in_col, in_row};
        end
        if (wr_en)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= item_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
        if (load)
        begin
            out_reg.last_column     <= cnt_zero ? 8'd0 : 8'(rdata_reg[ENTRY_W-1:COORD_BITS]);
            out_reg.last_row        <= cnt_zero ? 8'd0 : 8'(rdata_reg[COORD_BITS-1:0]);
            out_reg.list_empty      <= cnt_zero;
            out_reg.entry_total     <= 7'(cnt_reg);
            out_reg.was_added       <= added_reg;
            out_reg.duplicate_found <= dup_reg;
            out_reg.store_full      <= full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({out_data.was_added, out_data.duplicate_found,
                                out_data.store_full}))
        else $error("result flags not exclusive");

    a_added_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.was_added) |-> !out_data.list_empty)
        else $error("added pair but stack reported empty");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> !in_ready)
        else $error("request taken while busy");

endmodule

/* dv/tb.sv */
// Testbench for coordinate_stack_unique_push: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import csup_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 22;
    localparam logic [7:0] COORD_MASK = 8'((1 << COORD_BITS) - 1);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // predictor state
    logic [7:0] stk_col [DEPTH];
    logic [7:0] stk_row [DEPTH];
    int         stk_count = 0;
    out_t       pending_views [$];

    int n_req = 0;
    int n_added = 0;
    int n_dup = 0;
    int n_full = 0;
    int n_empty_del = 0;
    int peak_count = 0;
    int n_results = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    bit idle_on = 1'b1;
    int stall_orders = 0;
    int stall_served = 0;
    int stall_left = 0;

    coordinate_stack_unique_push uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_views.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic out_t stack_update(input in_t req);
        out_t       view;
        logic [7:0] col;
        logic [7:0] row;
        logic       seen;
        int         i;
        view = '0;
        col  = req.column_in & COORD_MASK;
        row  = req.row_in & COORD_MASK;
        seen = 1'b0;
        if (req.mode == MODE_UNIQUE)
        begin
            for (i = 0; i < stk_count; i++)
            begin
                if (stk_col[i] == col && stk_row[i] == row)
                    seen = 1'b1;
            end
        end
        if (req.mode == MODE_APPEND || req.mode == MODE_UNIQUE)
        begin
            if (seen)
            begin
                view.duplicate_found = 1'b1;
                n_dup++;
            end
            else if (stk_count >= DEPTH)
            begin
                view.store_full = 1'b1;
                n_full++;
            end
            else
            begin
                stk_col[stk_count] = col;
                stk_row[stk_count] = row;
                stk_count++;
                view.was_added = 1'b1;
                n_added++;
            end
        end
        else if (req.mode == MODE_DELETE)
        begin
            if (stk_count > 0)
                stk_count--;
            else
                n_empty_del++;
        end
        if (stk_count > 0)
        begin
            view.last_column = stk_col[stk_count - 1];
            view.last_row    = stk_row[stk_count - 1];
        end
        view.list_empty  = (stk_count == 0);
        view.entry_total = 7'(stk_count);
        if (stk_count > peak_count)
            peak_count = stk_count;
        return view;
    endfunction

    // unique appends reuse a stored pair half of the time so duplicates are common
    function automatic in_t pick_request(input int w_app, input int w_uni, input int w_del);
        in_t req;
        int  roll;
        int  slot;
        roll          = $urandom_range(99);
        req.column_in = 8'($urandom);
        req.row_in    = 8'($urandom);
        if (roll < w_app)
            req.mode = MODE_APPEND;
        else if (roll < w_app + w_uni)
        begin
            req.mode = MODE_UNIQUE;
            if (stk_count > 0 && $urandom_range(1) == 1)
            begin
                slot          = $urandom_range(stk_count - 1);
                req.column_in = stk_col[slot];
                req.row_in    = stk_row[slot];
            end
        end
        else if (roll < w_app + w_uni + w_del)
            req.mode = MODE_DELETE;
        else
            req.mode = MODE_QUERY;
        return req;
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input in_t req);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        pending_views.push_back(stack_update(req));
        n_req++;
    endtask

    task automatic send_pair(input logic [1:0] mode, input logic [7:0] col,
                             input logic [7:0] row);
        in_t req;
        req.mode      = mode;
        req.column_in = col;
        req.row_in    = row;
        send_request(req);
    endtask

    task automatic run_random(input int count, input int w_app, input int w_uni,
                              input int w_del);
        repeat (count) send_request(pick_request(w_app, w_uni, w_del));
    endtask

    function automatic string view_text(input out_t v);
        return $sformatf("col %0d row %0d empty %0d total %0d added %0d dup %0d full %0d",
                         v.last_column, v.last_row, v.list_empty, v.entry_total,
                         v.was_added, v.duplicate_found, v.store_full);
    endfunction

    task automatic check_view(input out_t got);
        out_t want;
        if (pending_views.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result with no request pending: %s", view_text(got));
        end
        else
        begin
            want = pending_views.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("mismatch at result %0d", n_results);
                    $display("  expected %s", view_text(want));
                    $display("  actual   %s", view_text(got));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            check_view(out_data);
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_served != stall_orders)
        begin
            out_ready    <= 1'b0;
            stall_served <= stall_orders;
            stall_left   <= HOLD_CYCLES - 1;
        end
        else if (idle_on && $urandom_range(99) < IDLE_PCT)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    task automatic test_directed_cases();
        send_pair(MODE_QUERY,  8'h00, 8'h00);
        send_pair(MODE_DELETE, 8'hff, 8'hff);   // empty: ignored
        send_pair(MODE_APPEND, 8'h00, 8'h00);
        send_pair(MODE_APPEND, 8'hff, 8'hff);
        send_pair(MODE_UNIQUE, 8'hff, 8'hff);   // equal to newest
        send_pair(MODE_UNIQUE, 8'h00, 8'h00);   // equal to oldest
        send_pair(MODE_UNIQUE, 8'hff, 8'h00);
        send_pair(MODE_UNIQUE, 8'h00, 8'hff);
        send_pair(MODE_APPEND, 8'h00, 8'h00);   // plain append keeps duplicates
        send_pair(MODE_QUERY,  8'h5a, 8'ha5);
        send_pair(MODE_DELETE, 8'h00, 8'h00);
        send_pair(MODE_DELETE, 8'h00, 8'h00);
        send_pair(MODE_QUERY,  8'h00, 8'h00);
        send_pair(MODE_UNIQUE, 8'ha5, 8'h5a);
        repeat (4) send_pair(MODE_DELETE, 8'h00, 8'h00);
        send_pair(MODE_DELETE, 8'h00, 8'h00);
        send_pair(MODE_QUERY,  8'hff, 8'hff);
        send_pair(MODE_UNIQUE, 8'h80, 8'h01);
        send_pair(MODE_DELETE, 8'h00, 8'h00);
    endtask

    task automatic test_fill_past_full();
        run_random(250, 40, 40, 5);
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        stall_orders <= stall_orders + 1;
        run_random(30, 25, 50, 10);
        idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_random(300, 30, 35, 25);
        idle_on = 1'b1;
    endtask

    task automatic test_drain_to_empty();
        run_random(200, 15, 15, 55);
    endtask

    task automatic test_mixed_traffic();
        run_random(250, 30, 30, 25);
        run_random(250, 45, 40, 10);
        run_random(250, 25, 25, 40);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_past_full();
        test_output_backpressure();
        test_back_to_back();
        test_drain_to_empty();
        test_mixed_traffic();

        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);

        $display("%0d requests, %0d results: %0d pairs stored, %0d duplicates refused, %0d refused full",
                 n_req, n_results, n_added, n_dup, n_full);
        $display("%0d deletes on an empty stack, deepest stack %0d of %0d, %0d mismatches",
                 n_empty_del, peak_count, DEPTH, mismatch_count);
        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
